[src/erf_pkg.sv]
// ----------------------------------------------------------------------------
// erf_pkg
// shared constants and types of the enclosed region fill block
// ----------------------------------------------------------------------------
`default_nettype none

package erf_pkg;

   localparam int CFG_W        = 7;
   localparam int DATA_W       = 64;
   localparam int ROW_IDX_W    = 6;
   localparam int CSR_IDX_W    = 1;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(64);

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = CSR_IDX_W'(1);

   // per-row control for the row update unit
   typedef struct packed {
      logic seed;
      logic has_prev;
      logic has_next;
   } row_ctl_type;

endpackage

`default_nettype wire

[src/erf_row_unit.sv]
// ----------------------------------------------------------------------------
// erf_row_unit
// shared row update: border seeding and one step of 4-neighbor growth
// ----------------------------------------------------------------------------
`default_nettype none

module erf_row_unit #(
   parameter int COL_W = 64
) (
   input  wire erf_pkg::row_ctl_type ctl,
   input  wire logic [COL_W-1:0]     open_row,
   input  wire logic [COL_W-1:0]     edge_cols,
   input  wire logic [COL_W-1:0]     prev_row,
   input  wire logic [COL_W-1:0]     cur_row,
   input  wire logic [COL_W-1:0]     next_row,
   output logic      [COL_W-1:0]     new_row,
   output logic                      row_changed
);
   import erf_pkg::*;

   logic [COL_W-1:0] grow;
   logic             edge_row;

   always_comb begin
      edge_row = !ctl.has_prev || !ctl.has_next;
      grow = cur_row | (cur_row << 1) | (cur_row >> 1);
      if (ctl.has_prev) begin
         grow = grow | prev_row;
      end
      if (ctl.has_next) begin
         grow = grow | next_row;
      end
      if (ctl.seed) begin
         new_row = edge_row ? open_row : (open_row & edge_cols);
      end else begin
         new_row = grow & open_row;
      end
      row_changed = (new_row != cur_row);
   end

endmodule

`default_nettype wire

[src/enclosed_region_fill.sv]
// ----------------------------------------------------------------------------
// enclosed_region_fill
// closes every open cell of a binary grid that has no 4-connected open path
// to the border; rows load one per transfer, results stream out per row
// ----------------------------------------------------------------------------
// sequence: rows load one per accepted transfer; after the last row, border
//   seeding visits every row (a read state, then a write state), then growth
//   sweeps over all rows repeat until one sweep changes nothing
// flow: one grid at a time; each result row is held until rsp_ready
// reset: row_count and col_count go to 64, load count and control clear,
//   grid and reach memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module enclosed_region_fill #(
   parameter int MAX_ROWS = erf_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = erf_pkg::DEF_MAX_COLS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [erf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [erf_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [erf_pkg::DATA_W-1:0]     req_open_cells,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [erf_pkg::DATA_W-1:0]     rsp_filled_row,
   output logic      [erf_pkg::ROW_IDX_W-1:0]  rsp_row_index,
   output logic                                rsp_last_row
);
   import erf_pkg::*;

   localparam int ROW_LIMIT = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int COL_W     = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int IDX_W     = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
   localparam int CNT_W     = $clog2(ROW_LIMIT + 1);

   typedef enum logic [6:0] {
      S_LOAD    = 7'b0000001,
      S_SEED_RD = 7'b0000010,
      S_SEED_WR = 7'b0000100,
      S_PROP_RD = 7'b0001000,
      S_PROP_WR = 7'b0010000,
      S_OUT_RD  = 7'b0100000,
      S_OUT_SET = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [CFG_W-1:0] col_count_ff, col_count_in;
   logic [CNT_W-1:0] rows_loaded_ff, rows_loaded_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic             changed_ff, changed_in;
   logic [COL_W-1:0] prev_ff, prev_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [ROW_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COL_W-1:0] grid_mem [ROW_LIMIT];
   logic [COL_W-1:0] reach_mem [ROW_LIMIT];
   logic [COL_W-1:0] grid_rd_ff;
   logic [COL_W-1:0] reach_rd0_ff;
   logic [COL_W-1:0] reach_rd1_ff;

   logic             grid_we;
   logic [IDX_W-1:0] grid_wa;
   logic [COL_W-1:0] grid_wd;
   logic             reach_we;
   logic [IDX_W-1:0] reach_ra1;

   logic [CNT_W-1:0] rows_cnt;
   logic [IDX_W-1:0] rows_last;
   logic [CFG_W-1:0] cols;
   logic [COL_W-1:0] mask;
   logic [COL_W-1:0] edge_cols;
   logic [IDX_W-1:0] slot;
   logic             at_last;

   row_ctl_type      ctl;
   logic [COL_W-1:0] new_row;
   logic             row_changed;

   // clamped geometry
   always_comb begin
      if (row_count_ff == '0) begin
         rows_cnt = CNT_W'(1);
      end else if (row_count_ff > CFG_W'(ROW_LIMIT)) begin
         rows_cnt = CNT_W'(ROW_LIMIT);
      end else begin
         rows_cnt = CNT_W'(row_count_ff);
      end
      rows_last = IDX_W'(rows_cnt - CNT_W'(1));
      if (col_count_ff == '0) begin
         cols = CFG_W'(1);
      end else if (col_count_ff > CFG_W'(COL_W)) begin
         cols = CFG_W'(COL_W);
      end else begin
         cols = col_count_ff;
      end
      if (cols >= CFG_W'(COL_W)) begin
         mask = '1;
      end else begin
         mask = (COL_W'(1) << cols) - COL_W'(1);
      end
      edge_cols = COL_W'(1) | (COL_W'(1) << (cols - CFG_W'(1)));
      if (rows_loaded_ff >= rows_cnt) begin
         slot = rows_last;
      end else begin
         slot = IDX_W'(rows_loaded_ff);
      end
      at_last   = (row_ff == rows_last);
      reach_ra1 = at_last ? row_ff : IDX_W'(row_ff + IDX_W'(1));
   end

   always_comb begin
      ctl.seed     = (state_ff == S_SEED_WR);
      ctl.has_prev = (row_ff != '0);
      ctl.has_next = !at_last;
   end

   erf_row_unit #(
      .COL_W (COL_W)
   ) u_row_unit (
      .ctl         (ctl),
      .open_row    (grid_rd_ff & mask),
      .edge_cols   (edge_cols),
      .prev_row    (prev_ff),
      .cur_row     (reach_rd0_ff),
      .next_row    (reach_rd1_ff),
      .new_row     (new_row),
      .row_changed (row_changed)
   );

   // memories
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_wa] <= grid_wd;
      end
      grid_rd_ff <= grid_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (reach_we) begin
         reach_mem[row_ff] <= new_row;
      end
      reach_rd0_ff <= reach_mem[row_ff];
      reach_rd1_ff <= reach_mem[reach_ra1];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      rows_loaded_in = rows_loaded_ff;
      row_in         = row_ff;
      changed_in     = changed_ff;
      prev_in        = prev_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_last_in    = rsp_last_ff;
      grid_we        = 1'b0;
      grid_wa        = slot;
      grid_wd        = req_open_cells[COL_W-1:0] & mask;
      reach_we       = 1'b0;
      req_ready      = (state_ff == S_LOAD);

      if (csr_we) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_wdata;
            REG_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               grid_we        = 1'b1;
               rows_loaded_in = CNT_W'(slot) + CNT_W'(1);
               if (slot == rows_last) begin
                  row_in   = '0;
                  state_in = S_SEED_RD;
               end
            end
         end
         S_SEED_RD: begin
            state_in = S_SEED_WR;
         end
         S_SEED_WR: begin
            reach_we = 1'b1;
            if (at_last) begin
               row_in     = '0;
               changed_in = 1'b0;
               state_in   = S_PROP_RD;
            end else begin
               row_in   = row_ff + IDX_W'(1);
               state_in = S_SEED_RD;
            end
         end
         S_PROP_RD: begin
            state_in = S_PROP_WR;
         end
         S_PROP_WR: begin
            reach_we = 1'b1;
            prev_in  = new_row;
            if (at_last) begin
               row_in     = '0;
               changed_in = 1'b0;
               state_in   = (changed_ff || row_changed) ? S_PROP_RD : S_OUT_RD;
            end else begin
               row_in     = row_ff + IDX_W'(1);
               changed_in = changed_ff || row_changed;
               state_in   = S_PROP_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_SET;
         end
         S_OUT_SET: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = DATA_W'(reach_rd0_ff);
               rsp_idx_in   = ROW_IDX_W'(row_ff);
               rsp_last_in  = at_last;
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  rows_loaded_in = '0;
                  row_in         = '0;
                  state_in       = S_LOAD;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_LOAD;
         row_count_ff   <= COUNT_RESET;
         col_count_ff   <= COUNT_RESET;
         rows_loaded_ff <= '0;
         row_ff         <= '0;
         changed_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         rows_loaded_ff <= rows_loaded_in;
         row_ff         <= row_in;
         changed_ff     <= changed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filled_row = rsp_row_ff;
   assign rsp_row_index  = rsp_idx_ff;
   assign rsp_last_row   = rsp_last_ff;

endmodule

`default_nettype wire
